// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks; only the top level includes them.
// No dependencies; each macro compiles to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("same-cycle implication check failed");

`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)

`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// File: hw/rtl/crtc_pkg.sv
// Shared types and constants of the CRT timing controller.
// No dependencies; used by every module of the block.
package crtc_pkg;

  localparam int NUM_REGS  = 18;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_WR_INDEX = 3'd1;
  localparam logic [2:0] KIND_WR_DATA  = 3'd2;
  localparam logic [2:0] KIND_RD_INDEX = 3'd3;
  localparam logic [2:0] KIND_RD_DATA  = 3'd4;

  localparam int R_HTOTAL     = 0;
  localparam int R_HDISP      = 1;
  localparam int R_HSYNC_POS  = 2;
  localparam int R_SYNC_WIDTH = 3;
  localparam int R_VTOTAL     = 4;
  localparam int R_VADJ       = 5;
  localparam int R_VDISP      = 6;
  localparam int R_VSYNC_POS  = 7;
  localparam int R_MAX_SCAN   = 9;
  localparam int R_CUR_START  = 10;
  localparam int R_CUR_END    = 11;
  localparam int R_START_HI   = 12;
  localparam int R_START_LO   = 13;
  localparam int R_CUR_HI     = 14;
  localparam int R_CUR_LO     = 15;

  localparam logic [7:0] WRITE_MASK [NUM_REGS] = '{
    8'hff, 8'hff, 8'hff, 8'h0f, 8'h7f, 8'h1f, 8'h7f, 8'h7f, 8'h03,
    8'h1f, 8'h7f, 8'h1f, 8'h3f, 8'hff, 8'h3f, 8'hff, 8'h00, 8'h00
  };

  localparam logic [7:0] READ_NONE = 8'hff;

  localparam logic [1:0] CUR_MODE_OFF  = 2'b01;
  localparam logic [1:0] CUR_MODE_SLOW = 2'b11;

  localparam int VSYNC_LINES = 16;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] bus_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] mem_addr;
    logic [5:0]  scan_line;
    logic        display_on;
    logic        hsync_on;
    logic        vsync_on;
    logic        cursor_on;
  } out_item_t;

  // Counter and register view after one item has taken effect.
  typedef struct packed {
    logic [7:0]  column;
    logic [7:0]  row;
    logic [5:0]  line;
    logic [4:0]  frame;
    logic [7:0]  read_data;
    logic [7:0]  hdisp;
    logic [7:0]  hsync_pos;
    logic [3:0]  sync_width;
    logic [6:0]  vdisp;
    logic [6:0]  vsync_pos;
    logic [4:0]  max_scan;
    logic [6:0]  cur_start;
    logic [4:0]  cur_end;
    logic [15:0] start_addr;
    logic [15:0] cursor_addr;
  } snap_t;

  typedef struct packed {
    logic load_s1;
    logic load_s2;
    logic load_out;
  } pipe_ctrl_t;

endpackage

// File: hw/rtl/crt_controller_timing_top.sv
// CRT timing controller top level: handshake control, counters and output pipeline.
// Depends on crtc_pkg, crtc_core, crtc_timing and assert_macros.svh.
`include "assert_macros.svh"

// The block takes one tick or bus access per clock while in_stall is low and
// returns one result for each. The counters and register file update in the
// cycle of the transfer, so a run of ticks advances one character per clock
// while the input is not stalled; the result then passes a snapshot register,
// a register after the two multipliers, and the output register.
// in_stall rises only when all three stages hold results that the output side
// has not taken.
module crt_controller_timing_top import crtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       v1_r, v2_r, vo_r;
  logic       ready1, ready2, ready_o;
  logic       accept;
  snap_t      snap;
  pipe_ctrl_t ctrl;

  assign ready_o  = !vo_r || !out_stall;
  assign ready2   = !v2_r || ready_o;
  assign ready1   = !v1_r || ready2;
  assign in_stall = !ready1;
  assign accept   = in_valid && ready1;

  assign ctrl.load_s1  = ready1;
  assign ctrl.load_s2  = ready2;
  assign ctrl.load_out = ready_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ready1) begin
        v1_r <= in_valid;
      end
      if (ready2) begin
        v2_r <= v1_r;
      end
      if (ready_o) begin
        vo_r <= v2_r;
      end
    end
  end

  crtc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .snap   (snap)
  );

  crtc_timing u_timing (
    .clk      (clk),
    .ctrl     (ctrl),
    .snap     (snap),
    .out_item (out_data)
  );

  assign out_valid = vo_r;

  `ASSERT_IMPLIES(a_empty_out_takes_input, clk, rst_n, !vo_r, !in_stall)
  `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, in_stall, v1_r && v2_r && vo_r)
  `ASSERT_NEXT(a_transfer_enters_stage1, clk, rst_n, in_valid && !in_stall, v1_r)
  `ASSERT_IMPLIES(a_cursor_needs_display, clk, rst_n, vo_r, !out_data.cursor_on || out_data.display_on)

endmodule

// File: hw/rtl/crtc_core.sv
// Register file, index register and raster counters of the CRT controller.
// Depends on crtc_pkg; updates on every transfer and exposes the post-transfer view.
module crtc_core import crtc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output snap_t    snap
);

  logic [7:0] regs_r   [NUM_REGS];
  logic [7:0] regs_nxt [NUM_REGS];
  logic [7:0] index_r, index_nxt;
  logic [7:0] column_r, column_nxt;
  logic [7:0] row_r, row_nxt;
  logic [5:0] line_r, line_nxt;
  logic [4:0] frame_r, frame_nxt;
  logic [6:0] line_inc;
  logic [7:0] rd;
  logic                 idx_ok;
  logic [REG_IDX_W-1:0] idx;

  assign idx_ok = index_r < 8'(NUM_REGS);
  assign idx    = index_r[REG_IDX_W-1:0];

  always_comb begin
    regs_nxt   = regs_r;
    index_nxt  = index_r;
    column_nxt = column_r;
    row_nxt    = row_r;
    line_nxt   = line_r;
    frame_nxt  = frame_r;
    line_inc   = {1'b0, line_r} + 7'd1;
    rd         = '0;
    unique case (item.kind)
      KIND_TICK: begin
        if (column_r < regs_r[R_HTOTAL]) begin
          column_nxt = column_r + 8'd1;
        end else begin
          column_nxt = '0;
          if (row_r <= regs_r[R_VTOTAL] && {1'b0, line_inc} > regs_r[R_MAX_SCAN]) begin
            line_inc = '0;
            row_nxt  = row_r + 8'd1;
          end
          if (row_nxt > regs_r[R_VTOTAL] && {1'b0, line_inc} >= regs_r[R_VADJ]) begin
            line_inc  = '0;
            row_nxt   = '0;
            frame_nxt = frame_r + 5'd1;
          end
          line_nxt = line_inc[5:0];
        end
      end
      KIND_WR_INDEX: begin
        index_nxt = item.bus_data;
      end
      KIND_WR_DATA: begin
        if (idx_ok) begin
          regs_nxt[idx] = item.bus_data & WRITE_MASK[idx];
        end
      end
      KIND_RD_INDEX: begin
        rd = index_r;
      end
      KIND_RD_DATA: begin
        rd = (idx_ok && index_r >= 8'(R_START_HI)) ? regs_r[idx] : READ_NONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
      index_r  <= '0;
      column_r <= '0;
      row_r    <= '0;
      line_r   <= '0;
      frame_r  <= '0;
    end else if (accept) begin
      regs_r   <= regs_nxt;
      index_r  <= index_nxt;
      column_r <= column_nxt;
      row_r    <= row_nxt;
      line_r   <= line_nxt;
      frame_r  <= frame_nxt;
    end
  end

  always_comb begin
    snap.column      = column_nxt;
    snap.row         = row_nxt;
    snap.line        = line_nxt;
    snap.frame       = frame_nxt;
    snap.read_data   = rd;
    snap.hdisp       = regs_nxt[R_HDISP];
    snap.hsync_pos   = regs_nxt[R_HSYNC_POS];
    snap.sync_width  = regs_nxt[R_SYNC_WIDTH][3:0];
    snap.vdisp       = regs_nxt[R_VDISP][6:0];
    snap.vsync_pos   = regs_nxt[R_VSYNC_POS][6:0];
    snap.max_scan    = regs_nxt[R_MAX_SCAN][4:0];
    snap.cur_start   = regs_nxt[R_CUR_START][6:0];
    snap.cur_end     = regs_nxt[R_CUR_END][4:0];
    snap.start_addr  = {regs_nxt[R_START_HI], regs_nxt[R_START_LO]};
    snap.cursor_addr = {regs_nxt[R_CUR_HI], regs_nxt[R_CUR_LO]};
  end

endmodule

// File: hw/rtl/crtc_timing.sv
// Output pipeline of the CRT controller: snapshot, multiply and compare stages.
// Depends on crtc_pkg; stage loads come from the handshake control in the top level.
module crtc_timing import crtc_pkg::*; (
  input  logic       clk,
  input  pipe_ctrl_t ctrl,
  input  snap_t      snap,
  output out_item_t  out_item
);

  typedef struct packed {
    logic [15:0] row_prod;
    logic [15:0] base;
    logic [15:0] cursor_addr;
    logic [13:0] vprod;
    logic [5:0]  line;
    logic [7:0]  read_data;
    logic        display;
    logic        hsync;
    logic        vsync_ge;
    logic        line_ok;
    logic        blink;
  } s2_t;

  snap_t     s1_r;
  s2_t       s2_r, s2_nxt;
  out_item_t out_r, out_nxt;
  logic [7:0]  hsync_off;
  logic [7:0]  vrow;
  logic [14:0] vsum;

  always_comb begin
    hsync_off          = s1_r.column - s1_r.hsync_pos;
    vrow               = s1_r.row - {1'b0, s1_r.vsync_pos};
    s2_nxt.row_prod    = {8'b0, s1_r.row} * {8'b0, s1_r.hdisp};
    s2_nxt.base        = {8'b0, s1_r.column} + s1_r.start_addr;
    s2_nxt.cursor_addr = s1_r.cursor_addr;
    s2_nxt.vprod       = {6'b0, vrow} * {8'b0, {1'b0, s1_r.max_scan} + 6'd1};
    s2_nxt.line        = s1_r.line;
    s2_nxt.read_data   = s1_r.read_data;
    s2_nxt.display     = (s1_r.column < s1_r.hdisp) && (s1_r.row < {1'b0, s1_r.vdisp});
    s2_nxt.hsync       = (s1_r.column >= s1_r.hsync_pos) &&
                         (hsync_off < {4'b0, s1_r.sync_width});
    s2_nxt.vsync_ge    = s1_r.row >= {1'b0, s1_r.vsync_pos};
    s2_nxt.line_ok     = (s1_r.line >= {1'b0, s1_r.cur_start[4:0]}) &&
                         (s1_r.line <= {1'b0, s1_r.cur_end});
    unique case (s1_r.cur_start[6:5])
      CUR_MODE_OFF:  s2_nxt.blink = 1'b0;
      CUR_MODE_SLOW: s2_nxt.blink = !s1_r.frame[4];
      default:       s2_nxt.blink = !s1_r.frame[3];
    endcase
  end

  always_comb begin
    vsum               = {1'b0, s2_r.vprod} + {9'b0, s2_r.line};
    out_nxt.read_data  = s2_r.read_data;
    out_nxt.mem_addr   = s2_r.row_prod + s2_r.base;
    out_nxt.scan_line  = s2_r.line;
    out_nxt.display_on = s2_r.display;
    out_nxt.hsync_on   = s2_r.hsync;
    out_nxt.vsync_on   = s2_r.vsync_ge && (vsum < 15'(VSYNC_LINES));
    out_nxt.cursor_on  = s2_r.display && (out_nxt.mem_addr == s2_r.cursor_addr) &&
                         s2_r.line_ok && s2_r.blink;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_s1) begin
      s1_r <= snap;
    end
    if (ctrl.load_s2) begin
      s2_r <= s2_nxt;
    end
    if (ctrl.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

// File: test/crtc_test_pkg.sv
// Testbench constants of the CRT timing controller that the block package leaves unnamed.
// No dependencies; imported by the checker and the testbench top.
package crtc_test_pkg;

  localparam int R_INTERLACE = 8;
  localparam int R_LPEN_HI   = 16;
  localparam int R_LPEN_LO   = 17;

  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

endpackage

// File: test/crtc_timing_checker.sv
// Checker for the CRT timing controller: it follows every transfer on both channels,
// predicts each result from its own copy of the registers and counters, and counts mismatches.
// Depends on crtc_pkg and crtc_test_pkg.
module crtc_timing_checker import crtc_pkg::*, crtc_test_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  logic [7:0] regs [NUM_REGS];
  logic [7:0] index_sel;
  logic [7:0] col;
  logic [7:0] row;
  logic [5:0] line;
  logic [4:0] frame;
  out_item_t  awaited[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [7:0] store_mask(int idx);
    case (idx)
      R_HTOTAL, R_HDISP, R_HSYNC_POS, R_START_LO, R_CUR_LO: return 8'hff;
      R_VTOTAL, R_VDISP, R_VSYNC_POS, R_CUR_START:          return 8'h7f;
      R_START_HI, R_CUR_HI:                                 return 8'h3f;
      R_VADJ, R_MAX_SCAN, R_CUR_END:                        return 8'h1f;
      R_SYNC_WIDTH:                                         return 8'h0f;
      R_INTERLACE:                                          return 8'h03;
      default:                                              return 8'h00;
    endcase
  endfunction

  function automatic void advance_char();
    int next_line;
    if (col < regs[R_HTOTAL]) begin
      col = col + 8'd1;
      return;
    end
    col = '0;
    next_line = int'(line) + 1;
    if (row <= regs[R_VTOTAL] && next_line > int'(regs[R_MAX_SCAN])) begin
      next_line = 0;
      row = row + 8'd1;
    end
    if (row > regs[R_VTOTAL] && next_line >= int'(regs[R_VADJ])) begin
      next_line = 0;
      row = '0;
      frame = frame + 5'd1;
    end
    line = next_line[5:0];
  endfunction

  function automatic out_item_t timing_view(logic [7:0] rd);
    out_item_t v;
    int addr;
    logic disp;
    addr = (int'(row) * int'(regs[R_HDISP]) + int'(col)
            + int'({regs[R_START_HI], regs[R_START_LO]})) & 'hffff;
    disp = col < regs[R_HDISP] && row < regs[R_VDISP];
    v.read_data = rd;
    v.mem_addr = addr[15:0];
    v.scan_line = line;
    v.display_on = disp;
    v.hsync_on = col >= regs[R_HSYNC_POS]
                 && int'(col) - int'(regs[R_HSYNC_POS]) < int'(regs[R_SYNC_WIDTH]);
    v.vsync_on = row >= regs[R_VSYNC_POS]
                 && (int'(row) - int'(regs[R_VSYNC_POS])) * (int'(regs[R_MAX_SCAN]) + 1)
                    + int'(line) < VSYNC_LINES;
    v.cursor_on = disp && addr == int'({regs[R_CUR_HI], regs[R_CUR_LO]})
                  && line >= regs[R_CUR_START][4:0] && line <= regs[R_CUR_END];
    if (v.cursor_on) begin
      case (regs[R_CUR_START][6:5])
        CUR_MODE_OFF:  v.cursor_on = 1'b0;
        CUR_MODE_SLOW: v.cursor_on = frame <= 5'd15;
        default:       v.cursor_on = frame[3:0] <= 4'd7;
      endcase
    end
    return v;
  endfunction

  function automatic out_item_t predict_result(in_item_t item);
    logic [7:0] rd;
    rd = '0;
    case (item.kind)
      KIND_TICK: advance_char();
      KIND_WR_INDEX: index_sel = item.bus_data;
      KIND_WR_DATA: begin
        if (index_sel < NUM_REGS) regs[index_sel] = item.bus_data & store_mask(index_sel);
      end
      KIND_RD_INDEX: rd = index_sel;
      KIND_RD_DATA: begin
        rd = (index_sel >= R_START_HI && index_sel < NUM_REGS) ? regs[index_sel] : READ_NONE;
      end
      default: ;
    endcase
    return timing_view(rd);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (regs[i]) regs[i] = '0;
      index_sel = '0;
      col = '0;
      row = '0;
      line = '0;
      frame = '0;
      awaited.delete();
    end else begin
      if (in_valid && !in_stall) awaited.push_back(predict_result(in_data));
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          fail_count++;
          $error("result transfer with no result awaited");
        end else begin
          want = awaited.pop_front();
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("mem_addr", want.mem_addr, out_data.mem_addr);
          check_field("scan_line", want.scan_line, out_data.scan_line);
          check_field("display_on", want.display_on, out_data.display_on);
          check_field("hsync_on", want.hsync_on, out_data.hsync_on);
          check_field("vsync_on", want.vsync_on, out_data.vsync_on);
          check_field("cursor_on", want.cursor_on, out_data.cursor_on);
        end
      end
    end
    pending = awaited.size();
  end

endmodule

// File: test/crt_controller_timing_top_test.sv
// Testbench top of the CRT timing controller: clock, reset, directed and random bus traffic,
// random stalls on the result side, a watchdog and the verdict.
// Depends on crtc_pkg, crtc_test_pkg, crtc_timing_checker and crt_controller_timing_top.
module crt_controller_timing_top_test;
  import crtc_pkg::*;
  import crtc_test_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 120;
  localparam int ITEM_TARGET = 700;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int pending;
  int quiet_cycles;
  int items_sent;
  int idle_pct;
  int stall_pct;
  bit long_hold;

  crt_controller_timing_top DUT (.*);

  crtc_timing_checker timing_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 20;
      default: return 50;
    endcase
  endfunction

  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(0, NUM_REGS - 1));
  endfunction

  function automatic logic [7:0] pick_value(int idx);
    int r;
    r = $urandom_range(0, 9);
    if (idx == R_CUR_START && r < 8)
      return {1'b0, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 7))};
    if (r < 6) return 8'($urandom_range(0, 7));
    if (r < 8) return 8'($urandom_range(0, 31));
    return 8'($urandom);
  endfunction

  task automatic drive_item(logic [2:0] kind, logic [7:0] data);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{kind: kind, bus_data: data};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (kind <= KIND_RD_DATA) items_sent++;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] value);
    drive_item(KIND_WR_INDEX, idx);
    drive_item(KIND_WR_DATA, value);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall = 1'b1;
        repeat (gap_len()) @(negedge clk);
      end
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] idx;
    int next_mode;
    bit hold_done;
    bit drained_mid;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    long_hold = 1'b0;
    items_sent = 0;
    next_mode = 0;
    hold_done = 1'b0;
    drained_mid = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    drive_item(KIND_TICK, 8'hff);
    write_reg(8'(R_START_HI), 8'hff);
    drive_item(KIND_RD_DATA, 8'h00);
    write_reg(8'(R_START_LO), 8'hff);
    drive_item(KIND_RD_INDEX, 8'h00);
    drive_item(KIND_RD_DATA, 8'h00);
    write_reg(8'(R_INTERLACE), 8'hff);
    drive_item(KIND_RD_DATA, 8'h00);
    write_reg(8'(R_LPEN_HI), 8'hff);
    drive_item(KIND_RD_DATA, 8'h00);
    write_reg(8'hff, 8'haa);
    drive_item(KIND_RD_DATA, 8'h00);
    drive_item(KIND_RD_INDEX, 8'h00);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) drive_item(3'(k), 8'hff);
    write_reg(8'(R_HTOTAL), 8'd5);
    repeat (4) drive_item(KIND_TICK, 8'h00);
    write_reg(8'(R_HTOTAL), 8'd1);
    drive_item(KIND_TICK, 8'h00);
    drain();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_mode) begin
        idle_pct = pick_pct();
        stall_pct = pick_pct();
        next_mode += 100;
      end
      if (!hold_done && items_sent >= 250) begin
        idle_pct = 0;
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (!drained_mid && items_sent >= 450) begin
        drain();
        drained_mid = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          idx = pick_index();
          write_reg(idx, (idx < NUM_REGS) ? pick_value(idx) : 8'($urandom));
        end
        3, 4, 5, 6: repeat ($urandom_range(1, 24)) drive_item(KIND_TICK, 8'($urandom));
        7: begin
          drive_item(KIND_WR_INDEX, pick_index());
          drive_item(KIND_RD_DATA, 8'($urandom));
          drive_item(KIND_RD_INDEX, 8'($urandom));
        end
        8: drive_item(KIND_RD_DATA, 8'($urandom));
        default: drive_item(3'($urandom), 8'($urandom));
      endcase
    end

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
